// ===== rtl/slr_pkg.sv =====
// shared types and constants of the stereo linear resampler
`default_nettype none

package slr_pkg;

   // width of the step size register word
   localparam int STEP_W = 21;

   // most results one input frame may cause
   localparam int MAX_OUT = 64;
   localparam int CNT_W   = 7;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;      // take the input word, open a new item
      logic mul;       // form the blend products, advance the phase
      logic run_end;   // close the current run, wrap the phase
      logic stage;     // round into the staging register
      logic flush;     // send the staged word as final, update held state
   } slr_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic more;        // another result is due in the current run
      logic to_second;   // final frame: a self-blend run follows
      logic pend_valid;  // staging register holds a result
      logic out_free;    // output register can take a word this cycle
   } slr_status_type;

endpackage

`default_nettype wire

// ===== rtl/slr_ctrl.sv =====
// controller state machine of the stereo linear resampler
`default_nettype none

module slr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  slr_pkg::slr_status_type status,
   output slr_pkg::slr_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_ROUND = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (status.more) begin
               cmd.mul  = 1'b1;
               state_in = S_ROUND;
            end else begin
               cmd.run_end = 1'b1;
               state_in    = status.to_second ? S_RUN : S_FLUSH;
            end
         end
         S_ROUND: begin
            if (!status.pend_valid || status.out_free) begin
               cmd.stage = 1'b1;
               state_in  = S_RUN;
            end
         end
         S_FLUSH: begin
            if (!status.pend_valid || status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/slr_datapath.sv =====
// datapath of the stereo linear resampler: held frame, phase, blend and output word
`default_nettype none

module slr_datapath #(
   parameter int FRAC_BITS   = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [SAMPLE_BITS-1:0]      req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0]      req_right_sample,
   input  logic                               req_last_frame,
   input  logic                               csr_valid,
   input  logic        [slr_pkg::STEP_W-1:0]  csr_step_size,
   input  slr_pkg::slr_cmd_type               cmd,
   output slr_pkg::slr_status_type            status,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right_out,
   output logic                               rsp_last_of_run,
   output logic                               rsp_end_of_stream
);

   localparam int PHASE_W = FRAC_BITS + 5;
   localparam int CLAMP_W = (slr_pkg::STEP_W > PHASE_W) ? slr_pkg::STEP_W : PHASE_W;
   localparam int ACC_W   = SAMPLE_BITS + FRAC_BITS + 2;
   localparam logic [PHASE_W-1:0] ONE_POS  = PHASE_W'(1) << FRAC_BITS;
   localparam logic [PHASE_W-1:0] STEP_MIN = ONE_POS >> 5;
   localparam logic [PHASE_W-1:0] STEP_MAX = ONE_POS << 4;
   localparam logic [slr_pkg::CNT_W-1:0] CNT_MAX = slr_pkg::CNT_W'(slr_pkg::MAX_OUT);

   // control registers
   logic [PHASE_W-1:0]         step_ff, step_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic                       have_held_ff, have_held_in;
   logic                       second_ff, second_in;
   logic [slr_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic                       out_valid_ff, out_valid_in;

   // payload registers
   logic signed [SAMPLE_BITS-1:0] held_l_ff, held_l_in, held_r_ff, held_r_in;
   logic signed [SAMPLE_BITS-1:0] cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic                          last_ff, last_in;
   logic signed [SAMPLE_BITS-1:0] base_l_ff, base_l_in, base_r_ff, base_r_in;
   logic signed [ACC_W-1:0]       prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   logic signed [SAMPLE_BITS-1:0] pend_l_ff, pend_l_in, pend_r_ff, pend_r_in;
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_l_in, out_r_ff, out_r_in;
   logic                          out_lor_ff, out_lor_in, out_eos_ff, out_eos_in;

   // step clamp on write
   logic [CLAMP_W-1:0] csr_wide;
   logic [PHASE_W-1:0] step_clamped;

   // blend operands
   logic signed [SAMPLE_BITS-1:0] opa_l, opa_r;
   logic signed [SAMPLE_BITS:0]   diff_l, diff_r;
   logic signed [FRAC_BITS:0]     frac_s;
   logic signed [ACC_W-1:0]       acc_l, acc_r, adj_l, adj_r;
   logic signed [SAMPLE_BITS-1:0] res_l, res_r;

   logic active;
   logic push;

   // clamp the written step to the range one thirty-second to sixteen
   always_comb begin
      csr_wide = CLAMP_W'(csr_step_size);
      if (csr_wide < CLAMP_W'(STEP_MIN)) begin
         step_clamped = STEP_MIN;
      end else if (csr_wide > CLAMP_W'(STEP_MAX)) begin
         step_clamped = STEP_MAX;
      end else begin
         step_clamped = csr_wide[PHASE_W-1:0];
      end
   end

   // the second run blends the final frame with itself
   assign opa_l  = second_ff ? cur_l_ff : held_l_ff;
   assign opa_r  = second_ff ? cur_r_ff : held_r_ff;
   assign diff_l = {cur_l_ff[SAMPLE_BITS-1], cur_l_ff} - {opa_l[SAMPLE_BITS-1], opa_l};
   assign diff_r = {cur_r_ff[SAMPLE_BITS-1], cur_r_ff} - {opa_r[SAMPLE_BITS-1], opa_r};
   assign frac_s = {1'b0, phase_ff[FRAC_BITS-1:0]};

   // a * one + (b - a) * f, then divide by one truncating toward zero
   always_comb begin
      acc_l = {{2{base_l_ff[SAMPLE_BITS-1]}}, base_l_ff, {FRAC_BITS{1'b0}}} + prod_l_ff;
      acc_r = {{2{base_r_ff[SAMPLE_BITS-1]}}, base_r_ff, {FRAC_BITS{1'b0}}} + prod_r_ff;
      adj_l = acc_l[ACC_W-1]
            ? acc_l + {{(SAMPLE_BITS+2){1'b0}}, {FRAC_BITS{1'b1}}} : acc_l;
      adj_r = acc_r[ACC_W-1]
            ? acc_r + {{(SAMPLE_BITS+2){1'b0}}, {FRAC_BITS{1'b1}}} : acc_r;
      res_l = adj_l[FRAC_BITS +: SAMPLE_BITS];
      res_r = adj_r[FRAC_BITS +: SAMPLE_BITS];
   end

   // status toward the controller
   assign active            = !second_ff || last_ff;
   assign status.more       = active && (phase_ff < ONE_POS) && (count_ff < CNT_MAX);
   assign status.to_second  = !second_ff && last_ff;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = !out_valid_ff || rsp_ready;

   assign push = (cmd.stage || cmd.flush) && pend_valid_ff;

   // next values
   always_comb begin
      step_in       = step_ff;
      phase_in      = phase_ff;
      have_held_in  = have_held_ff;
      second_in     = second_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff;
      held_l_in     = held_l_ff;
      held_r_in     = held_r_ff;
      cur_l_in      = cur_l_ff;
      cur_r_in      = cur_r_ff;
      last_in       = last_ff;
      base_l_in     = base_l_ff;
      base_r_in     = base_r_ff;
      prod_l_in     = prod_l_ff;
      prod_r_in     = prod_r_ff;
      pend_l_in     = pend_l_ff;
      pend_r_in     = pend_r_ff;
      out_l_in      = out_l_ff;
      out_r_in      = out_r_ff;
      out_lor_in    = out_lor_ff;
      out_eos_in    = out_eos_ff;

      if (csr_valid) begin
         step_in = step_clamped;
      end

      // new input frame
      if (cmd.load) begin
         cur_l_in  = req_left_sample;
         cur_r_in  = req_right_sample;
         last_in   = req_last_frame;
         count_in  = '0;
         second_in = !have_held_ff;
      end

      // products for one result
      if (cmd.mul) begin
         base_l_in = opa_l;
         base_r_in = opa_r;
         prod_l_in = ACC_W'(diff_l) * ACC_W'(frac_s);
         prod_r_in = ACC_W'(diff_r) * ACC_W'(frac_s);
         phase_in  = phase_ff + step_ff;
         count_in  = count_ff + slr_pkg::CNT_W'(1);
      end

      // end of a run
      if (cmd.run_end) begin
         if (active && (phase_ff >= ONE_POS)) begin
            phase_in = phase_ff - ONE_POS;
         end
         if (!second_ff && last_ff) begin
            second_in = 1'b1;
         end
      end

      // staging register
      if (cmd.stage) begin
         pend_l_in     = res_l;
         pend_r_in     = res_r;
         pend_valid_in = 1'b1;
      end
      if (cmd.flush) begin
         pend_valid_in = 1'b0;
         if (last_ff) begin
            held_l_in    = '0;
            held_r_in    = '0;
            phase_in     = '0;
            have_held_in = 1'b0;
         end else begin
            held_l_in    = cur_l_ff;
            held_r_in    = cur_r_ff;
            have_held_in = 1'b1;
         end
      end

      // output register
      if (push) begin
         out_l_in     = pend_l_ff;
         out_r_in     = pend_r_ff;
         out_lor_in   = cmd.flush;
         out_eos_in   = cmd.flush && last_ff;
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= ONE_POS;
         phase_ff      <= '0;
         have_held_ff  <= 1'b0;
         second_ff     <= 1'b0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         held_l_ff     <= '0;
         held_r_ff     <= '0;
      end else begin
         step_ff       <= step_in;
         phase_ff      <= phase_in;
         have_held_ff  <= have_held_in;
         second_ff     <= second_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         held_l_ff     <= held_l_in;
         held_r_ff     <= held_r_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cur_l_ff   <= cur_l_in;
      cur_r_ff   <= cur_r_in;
      last_ff    <= last_in;
      base_l_ff  <= base_l_in;
      base_r_ff  <= base_r_in;
      prod_l_ff  <= prod_l_in;
      prod_r_ff  <= prod_r_in;
      pend_l_ff  <= pend_l_in;
      pend_r_ff  <= pend_r_in;
      out_l_ff   <= out_l_in;
      out_r_ff   <= out_r_in;
      out_lor_ff <= out_lor_in;
      out_eos_ff <= out_eos_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_left_out      = out_l_ff;
   assign rsp_right_out     = out_r_ff;
   assign rsp_last_of_run   = out_lor_ff;
   assign rsp_end_of_stream = out_eos_ff;

endmodule

`default_nettype wire

// ===== rtl/stereo_linear_resampler_core.sv =====
// top level of the stereo linear resampler
// Linear-interpolation time stretcher for stereo PCM frames. Each frame taken on the req
// channel yields up to 64 words on the rsp channel; the output position advances by the
// unsigned Q5.16 step in csr_step_size (clamped to 1/32 .. 16 frames), and a frame flagged
// last is followed by copies of itself until the position passes it, after which the
// block clears its held frame and position but keeps its step. Results are truncated
// toward zero. Each result passes the multiplier stage and then the rounding stage, which
// fills a one-deep staging register and waits while that register is full and the rsp
// side stalls. The registered output word lets the next frame be taken while the last
// result still waits.
`default_nettype none

module stereo_linear_resampler_core #(
   parameter int FRAC_BITS   = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [SAMPLE_BITS-1:0]      req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0]      req_right_sample,
   input  logic                               req_last_frame,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right_out,
   output logic                               rsp_last_of_run,
   output logic                               rsp_end_of_stream,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic        [slr_pkg::STEP_W-1:0]  csr_step_size
);

   slr_pkg::slr_cmd_type    cmd;
   slr_pkg::slr_status_type status;

   // the step register takes a write in any cycle
   assign csr_ready = 1'b1;

   slr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   slr_datapath #(
      .FRAC_BITS   (FRAC_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_left_sample   (req_left_sample),
      .req_right_sample  (req_right_sample),
      .req_last_frame    (req_last_frame),
      .csr_valid         (csr_valid && csr_ready),
      .csr_step_size     (csr_step_size),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_left_out      (rsp_left_out),
      .rsp_right_out     (rsp_right_out),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

endmodule

`default_nettype wire

// ===== rtl/slr_checker.sv =====
// port-level checks of the stereo linear resampler and their binding
`default_nettype none

module slr_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input logic                          req_last_frame,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   input logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input logic                          rsp_last_of_run,
   input logic                          rsp_end_of_stream
);

   // a waiting input word holds until taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_left_sample)
         && $stable(req_right_sample) && $stable(req_last_frame))
      else $error("req word changed while waiting");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_out)
         && $stable(rsp_right_out) && $stable(rsp_last_of_run)
         && $stable(rsp_end_of_stream))
      else $error("rsp word changed while stalled");

   // end of stream only on the final word of a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_stream |-> rsp_last_of_run)
      else $error("end_of_stream without last_of_run");

   // one frame at a time: ready drops right after a take
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after a take");

   // no result appears in the cycle after a frame is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("rsp word too early after a take");

endmodule

bind stereo_linear_resampler_core slr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_slr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_left_sample   (req_left_sample),
   .req_right_sample  (req_right_sample),
   .req_last_frame    (req_last_frame),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_left_out      (rsp_left_out),
   .rsp_right_out     (rsp_right_out),
   .rsp_last_of_run   (rsp_last_of_run),
   .rsp_end_of_stream (rsp_end_of_stream)
);

`default_nettype wire
